// ===== rtl/core/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the bucketed peak/rms meter.
// ----------------------------------------------------------------------------
package bpm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_W       = 59;
  localparam int FRAME_W     = 29;
  localparam int BUCKET_W    = 15;
  localparam int ACC_W       = 34;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int ROOT_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BUCKETS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_FRAMES = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [BUCKET_W-1:0] MIN_BUCKETS = 15'd16;
  localparam logic [BUCKET_W-1:0] MAX_BUCKETS = 15'd16384;
  localparam logic [14:0]         LEVEL_MAX   = 15'h7FFF;

  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [13:0] bucket_index;
    logic [2:0]  channel;
    logic [14:0] peak;
    logic [14:0] rms;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [14:0] num_buckets;
    logic [31:0] stream_frames;
  } cfg_t;

  // header of one bucket close job
  typedef struct packed {
    logic [FRAME_W-1:0] frames;
    logic [13:0]        bucket;
    logic [4:0]         nch;
  } job_hdr_t;

endpackage

// ===== rtl/core/bucketed_peak_rms_meter.sv =====
// ----------------------------------------------------------------------------
// bucketed_peak_rms_meter
// Per-channel peak and rms level meter over fractional-length buckets.
// ----------------------------------------------------------------------------
// A sample transfer is taken and folded into its channel's peak and square
// sum in the next cycle; the input reports full while a sample is folded and
// while a closed bucket or a flush is handed over, and stays full longer while
// the two-entry job queue is full. Each close produces one result per effective
// channel, each passing through the back end in order: load, 59-step serial
// divider, 16-step serial square root, output; the output step waits while the
// previous result has not been popped. Configuration writes restart the
// stream.
module bucketed_peak_rms_meter #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  bpm_pkg::in_item_t                   in_item_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output bpm_pkg::out_item_t                  out_item_o
);

  bpm_pkg::cfg_t     cfg_q, cfg_d;
  logic              restart;
  logic              jq_push, jq_full, jq_pop, jq_empty;
  bpm_pkg::job_hdr_t fr_hdr, bk_hdr;
  logic [bpm_pkg::SAMPLE_BITS-1:0] fr_peak [MAX_CHANNELS];
  logic [bpm_pkg::SUM_W-1:0]       fr_sum  [MAX_CHANNELS];
  logic [bpm_pkg::SAMPLE_BITS-1:0] bk_peak [MAX_CHANNELS];
  logic [bpm_pkg::SUM_W-1:0]       bk_sum  [MAX_CHANNELS];

  // configuration registers
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bpm_pkg::REG_CHANNEL_COUNT: begin
          cfg_d.channel_count = cfg_wdata_i[3:0];
          restart = 1'b1;
        end
        bpm_pkg::REG_NUM_BUCKETS: begin
          cfg_d.num_buckets = cfg_wdata_i[14:0];
          restart = 1'b1;
        end
        bpm_pkg::REG_STREAM_FRAMES: begin
          cfg_d.stream_frames = cfg_wdata_i;
          restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= 4'd2;
      cfg_q.num_buckets   <= 15'd1024;
      cfg_q.stream_frames <= 32'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .restart_tf_i(cfg_d.stream_frames),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .jq_push_o   (jq_push),
    .jq_full_i   (jq_full),
    .jq_hdr_o    (fr_hdr),
    .jq_peak_o   (fr_peak),
    .jq_sum_o    (fr_sum)
  );

  bpm_jobq #(.MAX_CHANNELS(MAX_CHANNELS)) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (jq_push),
    .full_o (jq_full),
    .hdr_i  (fr_hdr),
    .peak_i (fr_peak),
    .sum_i  (fr_sum),
    .pop_i  (jq_pop),
    .empty_o(jq_empty),
    .hdr_o  (bk_hdr),
    .peak_o (bk_peak),
    .sum_o  (bk_sum)
  );

  bpm_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .jq_empty_i(jq_empty),
    .jq_pop_o  (jq_pop),
    .jq_hdr_i  (bk_hdr),
    .jq_peak_i (bk_peak),
    .jq_sum_i  (bk_sum),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_item_o(out_item_o)
  );

  // job queue never overflows or underflows
  a_jq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(jq_push && jq_full)) else $error("job pushed into full queue");

  a_jq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(jq_pop && jq_empty)) else $error("job popped from empty queue");

  // an accepted flush keeps the front busy for the following cycle
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !restart && in_item_i.op == bpm_pkg::OP_FLUSH) |=> full_o)
    else $error("front end idle right after a flush transfer");

endmodule

// ===== rtl/core/bpm_front.sv =====
// ----------------------------------------------------------------------------
// bpm_front
// Accepts samples, keeps per-channel peak and square sums, tracks bucket
// boundaries and posts a close job for every finished bucket.
// ----------------------------------------------------------------------------
module bpm_front #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpm_pkg::cfg_t                     cfg_i,
  input  logic                              restart_i,
  input  logic [31:0]                       restart_tf_i,
  input  logic                              push_i,
  output logic                              full_o,
  input  bpm_pkg::in_item_t                 in_item_i,
  output logic                              jq_push_o,
  input  logic                              jq_full_i,
  output bpm_pkg::job_hdr_t                 jq_hdr_o,
  output logic [bpm_pkg::SAMPLE_BITS-1:0]   jq_peak_o [MAX_CHANNELS],
  output logic [bpm_pkg::SUM_W-1:0]         jq_sum_o  [MAX_CHANNELS]
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = (MAX_CHANNELS < 2) ? 2 : $clog2(MAX_CHANNELS + 1);
  localparam int SB    = bpm_pkg::SAMPLE_BITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ACC  = 2'd1;
  localparam logic [1:0] F_EMIT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [SB-1:0]                peak_q [MAX_CHANNELS];
  logic [bpm_pkg::SUM_W-1:0]    sum_q  [MAX_CHANNELS];
  logic [bpm_pkg::FRAME_W-1:0]  frames_q;
  logic [CH_W-1:0]              pos_q;
  logic [bpm_pkg::ACC_W-1:0]    bound_q;
  logic [bpm_pkg::BUCKET_W-1:0] bucket_q;
  logic [SB-1:0]                mag_q;
  logic [CH_W-1:0]              cur_q;
  logic                         emit_q;
  logic                         flush_q;

  logic [CNT_W-1:0]             eff_ch;
  logic [bpm_pkg::BUCKET_W-1:0] eff_bk;
  logic                         active;
  logic [SB-1:0]                raw, mag;
  logic [CH_W-1:0]              pos_c;
  logic [CNT_W-1:0]             pos_inc;
  logic [bpm_pkg::ACC_W-1:0]    bound_n;
  logic [2*SB-1:0]              square;
  logic                         accept;

  // effective register values
  always_comb begin
    if (cfg_i.channel_count == 4'd0) begin
      eff_ch = CNT_W'(2);
    end else if (32'(cfg_i.channel_count) > 32'(MAX_CHANNELS)) begin
      eff_ch = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_ch = CNT_W'(cfg_i.channel_count);
    end
    if (32'(eff_ch) > 32'(MAX_CHANNELS)) begin
      eff_ch = CNT_W'(MAX_CHANNELS);
    end
    if (cfg_i.num_buckets < bpm_pkg::MIN_BUCKETS) begin
      eff_bk = bpm_pkg::MIN_BUCKETS;
    end else if (cfg_i.num_buckets > bpm_pkg::MAX_BUCKETS) begin
      eff_bk = bpm_pkg::MAX_BUCKETS;
    end else begin
      eff_bk = cfg_i.num_buckets;
    end
  end

  assign active  = (cfg_i.stream_frames != 32'd0) && (bucket_q < eff_bk);
  assign raw     = in_item_i.sample;
  assign mag     = raw[SB-1] ? (~raw + 1'b1) : raw;
  assign pos_c   = (CNT_W'(pos_q) >= eff_ch) ? '0 : pos_q;
  assign pos_inc = CNT_W'(cur_q) + 1'b1;
  assign bound_n = bound_q + bpm_pkg::ACC_W'(eff_bk);
  assign square  = mag_q * mag_q;
  assign accept  = push_i && !full_o;
  assign full_o  = (state_q != F_IDLE);

  // job toward the back end
  assign jq_push_o       = (state_q == F_EMIT) && emit_q && !jq_full_i;
  assign jq_hdr_o.frames = frames_q;
  assign jq_hdr_o.bucket = bucket_q[13:0];
  assign jq_hdr_o.nch    = 5'(eff_ch);
  assign jq_peak_o       = peak_q;
  assign jq_sum_o        = sum_q;

  // sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_item_i.op == bpm_pkg::OP_FLUSH) begin
            state_d = F_EMIT;
          end else if (active) begin
            state_d = F_ACC;
          end
        end
      end
      F_ACC: begin
        if (pos_inc >= eff_ch && !bound_n[bpm_pkg::ACC_W-1]) begin
          state_d = F_EMIT;
        end else begin
          state_d = F_IDLE;
        end
      end
      F_EMIT: begin
        if (!emit_q || !jq_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      frames_q <= '0;
      pos_q    <= '0;
      bucket_q <= '0;
      bound_q  <= bpm_pkg::ACC_W'(0) - bpm_pkg::ACC_W'(1);
      emit_q   <= 1'b0;
      flush_q  <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        peak_q[c] <= '0;
        sum_q[c]  <= '0;
      end
    end else if (restart_i) begin
      state_q  <= F_IDLE;
      frames_q <= '0;
      pos_q    <= '0;
      bucket_q <= '0;
      bound_q  <= bpm_pkg::ACC_W'(0) - bpm_pkg::ACC_W'(restart_tf_i);
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        peak_q[c] <= '0;
        sum_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            flush_q <= (in_item_i.op == bpm_pkg::OP_FLUSH);
            emit_q  <= active && (frames_q != '0);
          end
        end
        F_ACC: begin
          // fold the sample into its channel
          if (mag_q > peak_q[cur_q]) begin
            peak_q[cur_q] <= mag_q;
          end
          sum_q[cur_q] <= sum_q[cur_q] + bpm_pkg::SUM_W'(square);
          if (pos_inc < eff_ch) begin
            pos_q <= CH_W'(pos_inc);
          end else begin
            pos_q    <= '0;
            frames_q <= frames_q + 1'b1;
            if (!bound_n[bpm_pkg::ACC_W-1]) begin
              bound_q <= bound_n - bpm_pkg::ACC_W'(cfg_i.stream_frames);
              emit_q  <= 1'b1;
            end else begin
              bound_q <= bound_n;
            end
          end
        end
        F_EMIT: begin
          if (!emit_q || !jq_full_i) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
              peak_q[c] <= '0;
              sum_q[c]  <= '0;
            end
            frames_q <= '0;
            emit_q   <= 1'b0;
            if (flush_q) begin
              pos_q    <= '0;
              bucket_q <= '0;
              bound_q  <= bpm_pkg::ACC_W'(0) - bpm_pkg::ACC_W'(cfg_i.stream_frames);
            end else begin
              bucket_q <= bucket_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sample payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q <= mag;
      cur_q <= pos_c;
    end
  end

endmodule

// ===== rtl/core/bpm_jobq.sv =====
// ----------------------------------------------------------------------------
// bpm_jobq
// Two-entry queue of bucket close jobs between front and back end.
// ----------------------------------------------------------------------------
module bpm_jobq #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  bpm_pkg::job_hdr_t               hdr_i,
  input  logic [bpm_pkg::SAMPLE_BITS-1:0] peak_i [MAX_CHANNELS],
  input  logic [bpm_pkg::SUM_W-1:0]       sum_i  [MAX_CHANNELS],
  input  logic                            pop_i,
  output logic                            empty_o,
  output bpm_pkg::job_hdr_t               hdr_o,
  output logic [bpm_pkg::SAMPLE_BITS-1:0] peak_o [MAX_CHANNELS],
  output logic [bpm_pkg::SUM_W-1:0]       sum_o  [MAX_CHANNELS]
);

  localparam int DEPTH = 2;

  bpm_pkg::job_hdr_t               hdr_q  [DEPTH];
  logic [bpm_pkg::SAMPLE_BITS-1:0] peak_q [DEPTH][MAX_CHANNELS];
  logic [bpm_pkg::SUM_W-1:0]       sum_q  [DEPTH][MAX_CHANNELS];
  logic                            wr_q, rd_q;
  logic [1:0]                      cnt_q;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign hdr_o   = hdr_q[rd_q];
  assign peak_o  = peak_q[rd_q];
  assign sum_o   = sum_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      hdr_q[wr_q]  <= hdr_i;
      peak_q[wr_q] <= peak_i;
      sum_q[wr_q]  <= sum_i;
    end
  end

endmodule

// ===== rtl/core/bpm_back.sv =====
// ----------------------------------------------------------------------------
// bpm_back
// Turns a close job into per-channel results: serial divide of the square
// sum by the frame count, serial integer square root, then clamping of peak and rms.
// ----------------------------------------------------------------------------
module bpm_back #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            jq_empty_i,
  output logic                            jq_pop_o,
  input  bpm_pkg::job_hdr_t               jq_hdr_i,
  input  logic [bpm_pkg::SAMPLE_BITS-1:0] jq_peak_i [MAX_CHANNELS],
  input  logic [bpm_pkg::SUM_W-1:0]       jq_sum_i  [MAX_CHANNELS],
  output logic                            empty_o,
  input  logic                            pop_i,
  output bpm_pkg::out_item_t              out_item_o
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW    = bpm_pkg::SUM_W;
  localparam int FW    = bpm_pkg::FRAME_W;
  localparam int RW    = bpm_pkg::ROOT_W;
  localparam int CNT_W = $clog2(SW);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LOAD = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_SQRT = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]       state_q;
  logic [CH_W-1:0]  ch_q;
  logic [CNT_W-1:0] cnt_q;
  logic [FW-1:0]    rem_q;
  logic [SW-1:0]    dvd_q;
  logic [2*RW-1:0]  rad_q;
  logic [RW+1:0]    srem_q;
  logic [RW-1:0]    root_q;
  logic             sat_q;
  logic             ovalid_q;
  bpm_pkg::out_item_t out_q;

  logic [FW:0]      trial;
  logic             qbit;
  logic [RW+3:0]    s_sh;
  logic [RW+3:0]    s_try;
  logic             s_bit;
  logic             out_free;
  logic             last_ch;
  logic [bpm_pkg::SAMPLE_BITS-1:0] pk;
  bpm_pkg::out_item_t res;

  // one restoring divide step
  assign trial = {rem_q, dvd_q[SW-1]};
  assign qbit  = (trial >= (FW+1)'(jq_hdr_i.frames));

  // one square root step, two radicand bits at a time
  assign s_sh  = {srem_q, rad_q[2*RW-1 -: 2]};
  assign s_try = (RW+4)'({root_q, 2'b01});
  assign s_bit = (s_sh >= s_try);

  assign out_free = !ovalid_q || pop_i;
  assign last_ch  = (5'(ch_q) + 5'd1 == jq_hdr_i.nch);
  assign pk       = jq_peak_i[ch_q];
  assign jq_pop_o = (state_q == B_OUT) && out_free && last_ch;
  assign empty_o    = !ovalid_q;
  assign out_item_o = out_q;

  // result assembly with clamping
  always_comb begin
    res.bucket_index = jq_hdr_i.bucket;
    res.channel      = 3'(ch_q);
    res.peak         = pk[bpm_pkg::SAMPLE_BITS-1] ? bpm_pkg::LEVEL_MAX : pk[14:0];
    res.rms          = (sat_q || root_q[RW-1]) ? bpm_pkg::LEVEL_MAX : root_q[14:0];
    res.last_of_run  = last_ch;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ch_q     <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_i && ovalid_q) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!jq_empty_i) begin
            ch_q    <= '0;
            state_q <= B_LOAD;
          end
        end
        B_LOAD: begin
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SW - 1)) begin
            cnt_q   <= '0;
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(RW - 1)) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            ch_q     <= ch_q + 1'b1;
            state_q  <= last_ch ? B_IDLE : B_LOAD;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_LOAD: begin
        rem_q <= '0;
        dvd_q <= jq_sum_i[ch_q];
      end
      B_DIV: begin
        rem_q <= qbit ? FW'(trial - (FW+1)'(jq_hdr_i.frames)) : FW'(trial);
        dvd_q <= {dvd_q[SW-2:0], qbit};
        if (cnt_q == CNT_W'(SW - 1)) begin
          // quotient is complete once this bit lands
          rad_q  <= {dvd_q[2*RW-2:0], qbit};
          sat_q  <= (dvd_q[SW-2:2*RW-1] != '0);
          srem_q <= '0;
          root_q <= '0;
        end
      end
      B_SQRT: begin
        rad_q  <= {rad_q[2*RW-3:0], 2'b00};
        srem_q <= s_bit ? (RW+2)'(s_sh - s_try) : (RW+2)'(s_sh);
        root_q <= {root_q[RW-2:0], s_bit};
      end
      default: ;
    endcase
    if (state_q == B_OUT && out_free) begin
      out_q <= res;
    end
  end

endmodule

// ===== bench/bpm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpm_checker
// Watches the config, input and result channels of the level meter, keeps
// its own copy of the stream state and compares every result transfer.
// ----------------------------------------------------------------------------
module bpm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               push_i,
  input  logic                               full_i,
  input  bpm_pkg::in_item_t                  in_item_i,
  input  logic                               empty_i,
  input  logic                               pop_i,
  input  bpm_pkg::out_item_t                 out_item_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  logic [3:0]  chan_reg;
  logic [14:0] bucket_reg;
  logic [31:0] frames_reg;

  logic [15:0]                  peak_acc [8];
  logic [bpm_pkg::SUM_W-1:0]    square_acc [8];
  logic [bpm_pkg::FRAME_W-1:0]  frame_cnt;
  int unsigned                  chan_pos;
  longint                       boundary;
  int unsigned                  bucket_cur;

  bpm_pkg::out_item_t level_queue[$];

  assign pending_o = level_queue.size();

  function automatic int unsigned eff_chans();
    if (chan_reg == 0) return 2;
    if (chan_reg > 8) return 8;
    return 32'(chan_reg);
  endfunction

  function automatic int unsigned eff_buckets();
    if (bucket_reg < bpm_pkg::MIN_BUCKETS) return 32'(bpm_pkg::MIN_BUCKETS);
    if (bucket_reg > bpm_pkg::MAX_BUCKETS) return 32'(bpm_pkg::MAX_BUCKETS);
    return 32'(bucket_reg);
  endfunction

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  task automatic restart_stream();
    for (int c = 0; c < 8; c++) begin
      peak_acc[c] = 0;
      square_acc[c] = 0;
    end
    frame_cnt = 0;
    chan_pos = 0;
    bucket_cur = 0;
    boundary = -longint'(frames_reg);
  endtask

  task automatic close_bucket();
    int unsigned n;
    bpm_pkg::out_item_t r;
    logic [31:0] pk, rt;
    n = eff_chans();
    for (int unsigned c = 0; c < n; c++) begin
      pk = 32'(peak_acc[c]);
      rt = 0;
      if (pk > 32'(bpm_pkg::LEVEL_MAX)) pk = 32'(bpm_pkg::LEVEL_MAX);
      if (frame_cnt != 0) rt = int_sqrt(64'(square_acc[c]) / 64'(frame_cnt));
      if (rt > 32'(bpm_pkg::LEVEL_MAX)) rt = 32'(bpm_pkg::LEVEL_MAX);
      r.bucket_index = bucket_cur[13:0];
      r.channel = c[2:0];
      r.peak = pk[14:0];
      r.rms = rt[14:0];
      r.last_of_run = (c + 1 == n);
      level_queue.push_back(r);
      peak_acc[c] = 0;
      square_acc[c] = 0;
    end
    frame_cnt = 0;
  endtask

  task automatic fold_item(bpm_pkg::in_item_t it);
    logic [16:0] mag;
    int unsigned pos;
    if (it.op == bpm_pkg::OP_FLUSH) begin
      if (frames_reg != 0 && bucket_cur < eff_buckets() && frame_cnt != 0)
        close_bucket();
      restart_stream();
      return;
    end
    if (frames_reg == 0 || bucket_cur >= eff_buckets()) return;
    mag = it.sample[15] ? 17'h10000 - {1'b0, it.sample} : {1'b0, it.sample};
    pos = chan_pos;
    if (pos >= eff_chans()) pos = 0;
    if (mag > peak_acc[pos]) peak_acc[pos] = mag[15:0];
    square_acc[pos] += bpm_pkg::SUM_W'(mag) * bpm_pkg::SUM_W'(mag);
    pos++;
    if (pos < eff_chans()) begin
      chan_pos = pos;
      return;
    end
    chan_pos = 0;
    frame_cnt++;
    boundary += eff_buckets();
    if (boundary >= 0) begin
      close_bucket();
      boundary -= frames_reg;
      bucket_cur++;
    end
  endtask

  // predict on every transfer, compare on every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    bpm_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      chan_reg = 2;
      bucket_reg = 1024;
      frames_reg = 1;
      restart_stream();
      level_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (!empty_i && pop_i) begin
        if (level_queue.size() == 0) begin
          $error("unexpected result transfer %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = level_queue.pop_front();
          if (exp_item.bucket_index !== out_item_i.bucket_index ||
              exp_item.channel !== out_item_i.channel ||
              exp_item.peak !== out_item_i.peak ||
              exp_item.rms !== out_item_i.rms ||
              exp_item.last_of_run !== out_item_i.last_of_run)
            fail_count_o <= fail_count_o + 1;
          if (exp_item.bucket_index !== out_item_i.bucket_index)
            $error("bucket_index exp %0d got %0d", exp_item.bucket_index,
                   out_item_i.bucket_index);
          if (exp_item.channel !== out_item_i.channel)
            $error("channel exp %0d got %0d", exp_item.channel, out_item_i.channel);
          if (exp_item.peak !== out_item_i.peak)
            $error("peak exp %0d got %0d", exp_item.peak, out_item_i.peak);
          if (exp_item.rms !== out_item_i.rms)
            $error("rms exp %0d got %0d", exp_item.rms, out_item_i.rms);
          if (exp_item.last_of_run !== out_item_i.last_of_run)
            $error("last_of_run exp %0d got %0d", exp_item.last_of_run,
                   out_item_i.last_of_run);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == bpm_pkg::REG_CHANNEL_COUNT) chan_reg = cfg_wdata_i[3:0];
        else if (cfg_idx_i == bpm_pkg::REG_NUM_BUCKETS) bucket_reg = cfg_wdata_i[14:0];
        else if (cfg_idx_i == bpm_pkg::REG_STREAM_FRAMES) frames_reg = cfg_wdata_i;
        if (cfg_idx_i <= bpm_pkg::REG_STREAM_FRAMES) restart_stream();
      end
      if (push_i && !full_i) fold_item(in_item_i);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bucketed peak/rms meter: directed edge cases, then
// phases of random framed audio under several register settings, with
// bursty pushes and stalled pops. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint CYCLE_LIMIT = 2000000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           push_i = 1'b0;
  logic                           full_o;
  bpm_pkg::in_item_t              in_item_i = '0;
  logic                           empty_o;
  logic                           pop_i = 1'b0;
  bpm_pkg::out_item_t             out_item_o;
  int                             fail_count;
  int                             pending;
  longint                         cycle_cnt = 0;
  int unsigned                    burst_left = 0;

  bucketed_peak_rms_meter i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push_i, .full_o,
    .in_item_i, .empty_o, .pop_i, .out_item_o
  );

  bpm_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push_i,
    .full_i(full_o), .in_item_i, .empty_i(empty_o), .pop_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stall pattern: long clean stretches, then random stalls
  always @(posedge clk_i) begin
    if (cycle_cnt[11]) pop_i <= ($urandom_range(0, 3) != 0);
    else pop_i <= 1'b1;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one register write, then a wait with the write enable low
  task automatic write_reg(logic [bpm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one transfer, with bursty gaps before it; push stays high inside a burst
  task automatic send_item(logic op, logic [15:0] smp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        push_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    push_i <= 1'b1;
    in_item_i <= '{op: op, sample: smp};
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  // wait until every result has arrived and the back end is done
  task automatic drain();
    push_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80 * 8 * 2) @(posedge clk_i);
  endtask

  task automatic rand_frames(int unsigned nitems);
    logic [15:0] s;
    for (int unsigned i = 0; i < nitems; i++) begin
      case ($urandom_range(0, 9))
        0: s = 16'h8000;
        1: s = 16'h7FFF;
        default: s = 16'($urandom());
      endcase
      send_item((($urandom_range(0, 30) == 0) ? bpm_pkg::OP_FLUSH : bpm_pkg::OP_SAMPLE), s);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: one frame stream, tail frames ignored
    send_item(bpm_pkg::OP_SAMPLE, 16'h8000);
    send_item(bpm_pkg::OP_SAMPLE, 16'h7FFF);
    send_item(bpm_pkg::OP_SAMPLE, 16'h0001);
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();

    // small buckets, one channel, flush mid stream and with empty tail
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd1);
    write_reg(bpm_pkg::REG_NUM_BUCKETS, 32'd16);
    write_reg(bpm_pkg::REG_STREAM_FRAMES, 32'd40);
    send_item(bpm_pkg::OP_SAMPLE, 16'hFFFF);
    send_item(bpm_pkg::OP_SAMPLE, 16'h8000);
    send_item(bpm_pkg::OP_SAMPLE, 16'h0000);
    send_item(bpm_pkg::OP_SAMPLE, 16'h5555);
    send_item(bpm_pkg::OP_SAMPLE, 16'hAAAA);
    send_item(bpm_pkg::OP_FLUSH, 16'h1234);
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();

    // eight channels, flush mid frame; then zero and oversized counts
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd8);
    for (int i = 0; i < 11; i++) send_item(bpm_pkg::OP_SAMPLE, 16'(i * 3001));
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd0);
    write_reg(bpm_pkg::REG_NUM_BUCKETS, 32'd3);
    rand_frames(6);
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd15);
    write_reg(bpm_pkg::REG_NUM_BUCKETS, 32'h7FFF);
    write_reg(bpm_pkg::REG_STREAM_FRAMES, 32'd0);
    rand_frames(9);
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();

    // random phases over several settings
    write_reg(bpm_pkg::REG_STREAM_FRAMES, 32'hFFFF_FFFF);
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd3);
    write_reg(bpm_pkg::REG_NUM_BUCKETS, 32'd16);
    rand_frames(15);
    drain();
    write_reg(bpm_pkg::REG_NUM_BUCKETS, 32'd16384);
    write_reg(bpm_pkg::REG_STREAM_FRAMES, 32'd20);
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, 32'd2);
    rand_frames(25);
    drain();
    write_reg(bpm_pkg::REG_CHANNEL_COUNT, $urandom_range(1, 8));
    write_reg(bpm_pkg::REG_NUM_BUCKETS, $urandom_range(16, 64));
    write_reg(bpm_pkg::REG_STREAM_FRAMES, $urandom_range(16, 200));
    rand_frames(25);
    send_item(bpm_pkg::OP_FLUSH, 16'h0000);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
